>>> hdl/rrfsp_pkg.sv
// package: types and constants shared by the round-robin free slot picker
package rrfsp_pkg;

   localparam int MAX_SLOTS = 8;
   localparam int SLOT_BITS = $clog2(MAX_SLOTS);
   localparam int COUNT_BITS = $clog2(MAX_SLOTS + 1);
   localparam int REQ_SLOT_BITS = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 4;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ACQUIRE  = 2'd0,
      OP_SET_BUSY = 2'd1,
      OP_SET_FREE = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT   = 2'd1;
   localparam logic [1:0] STATUS_CANCELLED = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOT_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CANCELLED     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOTIFY_ENABLE = 2'd2;

   typedef struct packed {
      logic [1:0]               operation;
      logic [REQ_SLOT_BITS-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [SLOT_BITS-1:0] granted_slot;
      logic                 is_busy;
      logic                 release_notice;
      logic [SLOT_BITS-1:0] released_slot;
   } rsp_type;

   typedef struct packed {
      op_type               op;
      logic [SLOT_BITS-1:0] slot;
      logic                 in_range;
   } cmd_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] eff_count;
      logic                  cancelled;
      logic                  notify_enable;
   } cfg_type;

endpackage

>>> hdl/rrfsp_front.sv
// front end: accepts transactions, classifies them and hands them to the queue
module rrfsp_front import rrfsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   input  logic [COUNT_BITS-1:0] eff_count,
   input  logic                  fifo_full,
   output logic                  push,
   output cmd_type               push_cmd
);

   logic    stage_valid_ff, stage_valid_in;
   cmd_type stage_ff, stage_in;
   cmd_type classified;
   logic    accept;

   always_comb begin
      classified.op       = op_type'(req_payload.operation);
      classified.slot     = req_payload.slot[SLOT_BITS-1:0];
      classified.in_range = req_payload.slot < REQ_SLOT_BITS'(eff_count);
   end

   assign busy     = stage_valid_ff && fifo_full;
   assign accept   = start && !busy;
   assign push     = stage_valid_ff && !fifo_full;
   assign push_cmd = stage_ff;

   always_comb begin
      stage_valid_in = accept || (stage_valid_ff && !push);
      stage_in       = accept ? classified : stage_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

endmodule

>>> hdl/rrfsp_fifo.sv
// short command queue between front end and back end
module rrfsp_fifo import rrfsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    full,
   output logic    empty
);

   cmd_type                  entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     do_push, do_pop;

   assign full    = count_ff == FIFO_CNT_BITS'(FIFO_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> hdl/rrfsp_back.sv
// back end: busy bits, round-robin pointer, slot scan and result register
module rrfsp_back import rrfsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    fifo_empty,
   input  cmd_type fifo_cmd,
   output logic    pop,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WRAP = 3'b010,
      ST_SCAN = 3'b100
   } back_state_type;

   back_state_type        state_ff, state_in;
   logic [MAX_SLOTS-1:0]  busy_bits_ff, busy_bits_in;
   logic [SLOT_BITS-1:0]  ptr_ff, ptr_in;
   logic [SLOT_BITS-1:0]  idx_ff, idx_in;
   logic [COUNT_BITS-1:0] left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [SLOT_BITS-1:0]  idx_next;

   assign pop         = (state_ff == ST_IDLE) && !fifo_empty;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      if (COUNT_BITS'(idx_ff) + 1'b1 == cfg.eff_count) begin
         idx_next = '0;
      end else begin
         idx_next = idx_ff + 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      busy_bits_in = busy_bits_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               unique case (fifo_cmd.op)
                  OP_ACQUIRE: begin
                     if (cfg.cancelled) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_CANCELLED;
                     end else if (cfg.eff_count == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_TIMEOUT;
                     end else begin
                        idx_in   = ptr_ff;
                        state_in = ST_WRAP;
                     end
                  end
                  OP_SET_BUSY: begin
                     rsp_valid_in = 1'b1;
                     if (fifo_cmd.in_range) begin
                        busy_bits_in[fifo_cmd.slot] = 1'b1;
                     end
                  end
                  OP_SET_FREE: begin
                     rsp_valid_in = 1'b1;
                     if (fifo_cmd.in_range && busy_bits_ff[fifo_cmd.slot]) begin
                        busy_bits_in[fifo_cmd.slot] = 1'b0;
                        if (cfg.notify_enable) begin
                           rsp_in.release_notice = 1'b1;
                           rsp_in.released_slot  = fifo_cmd.slot;
                        end
                     end
                  end
                  OP_QUERY: begin
                     rsp_valid_in   = 1'b1;
                     rsp_in.is_busy = fifo_cmd.in_range && busy_bits_ff[fifo_cmd.slot];
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WRAP: begin
            // bring the start index below the slot count
            if (COUNT_BITS'(idx_ff) >= cfg.eff_count) begin
               idx_in = SLOT_BITS'(COUNT_BITS'(idx_ff) - cfg.eff_count);
            end else begin
               left_in  = cfg.eff_count;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!busy_bits_ff[idx_ff]) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = STATUS_OK;
               rsp_in.granted_slot = idx_ff;
               ptr_in              = idx_next;
               state_in            = ST_IDLE;
            end else if (left_ff == COUNT_BITS'(1)) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_TIMEOUT;
               state_in      = ST_IDLE;
            end else begin
               left_in = left_ff - 1'b1;
               idx_in  = idx_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_bits_ff <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_bits_ff <= busy_bits_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      left_ff <= left_in;
      rsp_ff  <= rsp_in;
   end

endmodule

>>> hdl/round_robin_free_slot_picker.sv
// top level: round-robin free slot picker with configuration registers
//
//   channel   ports                                   handshake
//   request   start, busy, req_payload                start && !busy
//   result    rsp_valid, rsp_payload                  one-cycle strobe
//   config    csr_valid, csr_ready, csr_index, csr_data  valid && ready
//
// set busy, set free, query and a cancelled or zero-slot acquire are answered from
// the idle state once they leave the front stage and the queue.
// other acquires first bring the pointer below the slot count in the wrap state,
// then check one busy bit per cycle over up to the slot count in the scan state.
// reset clears busy bits, pointer and registers.
// the receiver cannot stall; transactions behind an acquire wait in the queue and
// busy rises when the front stage and queue are full.
module round_robin_free_slot_picker import rrfsp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_payload,
   output logic                      rsp_valid,
   output rsp_type                   rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [CSR_DATA_BITS-1:0] slot_count_ff, slot_count_in;
   logic                     cancelled_ff, cancelled_in;
   logic                     notify_ff, notify_in;
   cfg_type                  cfg;
   logic                     push, pop, fifo_full, fifo_empty;
   cmd_type                  push_cmd, pop_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      slot_count_in = slot_count_ff;
      cancelled_in  = cancelled_ff;
      notify_in     = notify_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SLOT_COUNT:    slot_count_in = csr_data;
            CSR_CANCELLED:     cancelled_in  = csr_data[0];
            CSR_NOTIFY_ENABLE: notify_in     = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= '0;
         cancelled_ff  <= 1'b0;
         notify_ff     <= 1'b0;
      end else begin
         slot_count_ff <= slot_count_in;
         cancelled_ff  <= cancelled_in;
         notify_ff     <= notify_in;
      end
   end

   always_comb begin
      if (slot_count_ff > CSR_DATA_BITS'(MAX_SLOTS)) begin
         cfg.eff_count = COUNT_BITS'(MAX_SLOTS);
      end else begin
         cfg.eff_count = COUNT_BITS'(slot_count_ff);
      end
      cfg.cancelled     = cancelled_ff;
      cfg.notify_enable = notify_ff;
   end

   rrfsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .eff_count   (cfg.eff_count),
      .fifo_full   (fifo_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   rrfsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   rrfsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .fifo_empty  (fifo_empty),
      .fifo_cmd    (pop_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK |-> rsp_payload.granted_slot == '0)
      else $error("granted slot set on a failed acquire");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.release_notice |-> notify_ff
         && COUNT_BITS'(rsp_payload.released_slot) < cfg.eff_count)
      else $error("release notice without notify or out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.granted_slot != '0
         |-> COUNT_BITS'(rsp_payload.granted_slot) < cfg.eff_count)
      else $error("granted slot beyond slot count");
`endif

endmodule

>>> tb/round_robin_free_slot_picker_tb.sv
// testbench: round-robin free slot picker checked item by item against a behavioral predictor
module round_robin_free_slot_picker_tb;
   import rrfsp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 25;
   localparam int RANDOM_ITEMS = 1400;
   localparam int FINAL_ITEMS = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_payload = '0;
   logic rsp_valid;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // mirror of the block state and registers
   logic [MAX_SLOTS-1:0] slot_busy = '0;
   logic [SLOT_BITS-1:0] rr_pointer = '0;
   logic [CSR_DATA_BITS-1:0] cfg_slot_count = '0;
   logic cfg_cancelled = 1'b0;
   logic cfg_notify = 1'b0;

   rsp_type expected_rsp_q[$];
   bit idle_enable = 1'b0;
   int error_count = 0;
   int cycle_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int op_count [4] = '{default: 0};
   int grant_count = 0;
   int timeout_count = 0;
   int cancel_count = 0;
   int notice_count = 0;

   round_robin_free_slot_picker u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_rsp_q.size());
         $display("status: fail");
         $finish;
      end
   end

   function automatic int effective_slots();
      return (cfg_slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_slot_count);
   endfunction

   function automatic rsp_type predict_picker_rsp(req_type item);
      rsp_type res;
      int count;
      int first;
      int idx;
      bit found;
      logic [SLOT_BITS-1:0] slot_idx;
      res = '0;
      count = effective_slots();
      found = 1'b0;
      slot_idx = item.slot[SLOT_BITS-1:0];
      op_count[item.operation]++;
      case (op_type'(item.operation))
         OP_ACQUIRE: begin
            if (cfg_cancelled) begin
               res.status = STATUS_CANCELLED;
               cancel_count++;
            end else begin
               if (count > 0) begin
                  // search wraps at the slot count, start reduced below it
                  first = int'(rr_pointer) % count;
                  for (int i = 0; i < count && !found; i++) begin
                     idx = (first + i) % count;
                     if (!slot_busy[idx]) begin
                        found = 1'b1;
                        res.granted_slot = SLOT_BITS'(idx);
                        rr_pointer = SLOT_BITS'((idx + 1) % count);
                     end
                  end
               end
               res.status = found ? STATUS_OK : STATUS_TIMEOUT;
               if (found) grant_count++;
               else timeout_count++;
            end
         end
         OP_SET_BUSY: begin
            if (item.slot < count) slot_busy[slot_idx] = 1'b1;
         end
         OP_SET_FREE: begin
            if (item.slot < count && slot_busy[slot_idx]) begin
               slot_busy[slot_idx] = 1'b0;
               if (cfg_notify) begin
                  res.release_notice = 1'b1;
                  res.released_slot = slot_idx;
                  notice_count++;
               end
            end
         end
         default: begin
            res.is_busy = (item.slot < count) && slot_busy[slot_idx];
         end
      endcase
      return res;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            $error("result transaction with nothing expected: %p", rsp_payload);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("status", want.status, rsp_payload.status);
            check_field("granted_slot", want.granted_slot, rsp_payload.granted_slot);
            check_field("is_busy", want.is_busy, rsp_payload.is_busy);
            check_field("release_notice", want.release_notice, rsp_payload.release_notice);
            check_field("released_slot", want.released_slot, rsp_payload.released_slot);
            checked_count++;
         end
      end
   end

   task automatic send_item(input op_type op, input logic [REQ_SLOT_BITS-1:0] slot);
      req_type item;
      item.operation = op;
      item.slot = slot;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      expected_rsp_q.push_back(predict_picker_rsp(item));
      sent_count++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_SLOT_COUNT: cfg_slot_count = data;
         CSR_CANCELLED: cfg_cancelled = data[0];
         CSR_NOTIFY_ENABLE: cfg_notify = data[0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input int count, input bit cancel, input bit notify);
      write_register(CSR_SLOT_COUNT, CSR_DATA_BITS'(count));
      write_register(CSR_CANCELLED, CSR_DATA_BITS'(cancel));
      write_register(CSR_NOTIFY_ENABLE, CSR_DATA_BITS'(notify));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [REQ_SLOT_BITS-1:0] random_slot();
      int count;
      count = effective_slots();
      case ($urandom_range(0, 9))
         0: return REQ_SLOT_BITS'($urandom_range(0, 255));
         1, 2: return REQ_SLOT_BITS'($urandom_range(count, count + 2));
         default: return REQ_SLOT_BITS'($urandom_range(0, (count > 0) ? count - 1 : MAX_SLOTS - 1));
      endcase
   endfunction

   function automatic op_type random_op(int busy_weight, int free_weight);
      int pick;
      pick = $urandom_range(0, 4 + busy_weight + free_weight);
      if (pick < 3) return OP_ACQUIRE;
      if (pick < 3 + busy_weight) return OP_SET_BUSY;
      if (pick < 3 + busy_weight + free_weight) return OP_SET_FREE;
      return OP_QUERY;
   endfunction

   // registers still at reset values: zero slots
   task automatic test_reset_defaults();
      send_item(OP_ACQUIRE, 8'd0);
      send_item(OP_SET_BUSY, 8'd0);
      send_item(OP_QUERY, 8'd0);
      drain_results();
   endtask

   task automatic test_basic_grants();
      apply_config(MAX_SLOTS, 1'b0, 1'b1);
      send_item(OP_ACQUIRE, 8'h00);
      send_item(OP_ACQUIRE, 8'hff);
      send_item(OP_SET_BUSY, 8'd2);
      send_item(OP_SET_BUSY, 8'd3);
      send_item(OP_ACQUIRE, 8'd0);
      send_item(OP_QUERY, 8'd3);
      send_item(OP_QUERY, 8'd255);
      send_item(OP_SET_FREE, 8'd3);
      send_item(OP_SET_FREE, 8'd3);
      send_item(OP_SET_BUSY, 8'd8);
      send_item(OP_QUERY, 8'd8);
      drain_results();
   endtask

   // pointer left beyond a reduced count, then every slot busy
   task automatic test_shrunk_count();
      apply_config(3, 1'b0, 1'b1);
      send_item(OP_ACQUIRE, 8'd0);
      send_item(OP_SET_BUSY, 8'd0);
      send_item(OP_SET_BUSY, 8'd1);
      send_item(OP_SET_BUSY, 8'd2);
      send_item(OP_ACQUIRE, 8'd0);
      send_item(OP_QUERY, 8'd2);
      drain_results();
   endtask

   task automatic test_cancel_and_clamp();
      apply_config(15, 1'b1, 1'b0);
      send_item(OP_ACQUIRE, 8'd0);
      drain_results();
      apply_config(15, 1'b0, 1'b0);
      send_item(OP_ACQUIRE, 8'd0);
      send_item(OP_SET_FREE, 8'd2);
      send_item(OP_QUERY, 8'd7);
      drain_results();
   endtask

   task automatic test_random_traffic();
      int issued;
      int phase_items;
      int busy_weight;
      int free_weight;
      int count;
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: count = 0;
            1: count = 15;
            2: count = $urandom_range(MAX_SLOTS + 1, 14);
            3: count = 1;
            4: count = MAX_SLOTS;
            default: count = $urandom_range(2, MAX_SLOTS);
         endcase
         apply_config(count, $urandom_range(0, 4) == 0, $urandom_range(0, 1));
         idle_enable = $urandom_range(0, 3) != 0;
         busy_weight = $urandom_range(1, 6);
         free_weight = $urandom_range(1, 6);
         phase_items = $urandom_range(40, 160);
         for (int n = 0; n < phase_items; n++) begin
            send_item(random_op(busy_weight, free_weight), random_slot());
         end
         issued += phase_items;
         drain_results();
      end
   endtask

   // closing stretch with the request side never idle
   task automatic test_back_to_back();
      idle_enable = 1'b0;
      apply_config(MAX_SLOTS, 1'b0, 1'b1);
      for (int n = 0; n < FINAL_ITEMS; n++) begin
         send_item(random_op(3, 3), random_slot());
      end
      drain_results();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_basic_grants();
      test_shrunk_count();
      test_cancel_and_clamp();
      test_random_traffic();
      test_back_to_back();
      if (expected_rsp_q.size() != 0) begin
         $error("%0d expected results never arrived", expected_rsp_q.size());
         error_count++;
      end
      $display("%0d transactions sent, %0d results checked, %0d mismatches",
               sent_count, checked_count, error_count);
      $display("acquire %0d (granted %0d, timeout %0d, cancelled %0d), set busy %0d, set free %0d (notices %0d), query %0d",
               op_count[OP_ACQUIRE], grant_count, timeout_count, cancel_count,
               op_count[OP_SET_BUSY], op_count[OP_SET_FREE], notice_count, op_count[OP_QUERY]);
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
